[sv/mia_pkg.sv]
package mia_pkg;

  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_ORDER       = 3;
  localparam int FRONT_STAGES    = 7;
  localparam int NUM_ENTRIES     = 9;
  localparam logic [1:0] ORDER_RESET = 2'd3;

  function automatic logic [1:0] clamp_order(input logic [1:0] ord);
    logic [1:0] res;
    res = ord;
    if (ord == 2'd0) begin
      res = 2'd1;
    end else if (ord > 2'(MAX_ORDER)) begin
      res = 2'(MAX_ORDER);
    end
    return res;
  endfunction

endpackage

[sv/mia_front.sv]
module mia_front #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                       clk,
  input  logic                                       adv,
  input  logic [1:0]                                 ord_n,
  input  logic signed [ENTRY_WIDTH-1:0]              m [9],
  output logic [2*ENTRY_WIDTH+2*FRAC_BITS-1:0]       num [9],
  output logic [3*ENTRY_WIDTH+1:0]                   den,
  output logic [8:0]                                 neg,
  output logic [8:0]                                 keep,
  output logic                                       ok
);
  import mia_pkg::*;

  localparam int W  = ENTRY_WIDTH;
  localparam int NW = 2*W + 2*FRAC_BITS;
  localparam int DW = 3*W + 2;
  localparam int CW = 2*W + 1;
  localparam int PL = 2*W + 2;

  logic signed [W-1:0]    a     [3][3];
  logic signed [W-1:0]    a0_2  [3];
  logic signed [W-1:0]    a0_3  [3];
  logic signed [2*W-1:0]  p1    [3][3];
  logic signed [2*W-1:0]  p2    [3][3];
  logic signed [CW-1:0]   c3    [3][3];
  logic signed [CW-1:0]   c4    [3][3];
  logic signed [CW-1:0]   c5    [3][3];
  logic signed [CW-1:0]   c6    [3][3];
  logic signed [PL-1:0]   pl    [3];
  logic signed [2*W-1:0]  ph    [3];
  logic signed [DW-1:0]   t     [3];
  logic signed [DW-1:0]   det;
  logic [8:0]             kp    [1:6];
  logic [2*W-1:0]         cabs  [3][3];
  logic                   dnz;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (2'(i) < ord_n && 2'(j) < ord_n) begin
            a[i][j] <= m[i*3+j];
          end else if (i == j) begin
            a[i][j] <= W'(1);
          end else begin
            a[i][j] <= '0;
          end
          kp[1][i*3+j] <= (2'(i) < ord_n) && (2'(j) < ord_n);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1[i][j] <= a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3];
          p2[i][j] <= a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
          c3[i][j] <= CW'(p1[i][j]) - CW'(p2[i][j]);
          c4[i][j] <= c3[i][j];
          c5[i][j] <= c4[i][j];
          c6[i][j] <= c5[i][j];
        end
        a0_2[i] <= a[0][i];
        a0_3[i] <= a0_2[i];
        pl[i]   <= a0_3[i] * $signed({1'b0, c3[0][i][W:0]});
        ph[i]   <= a0_3[i] * $signed(c3[0][i][CW-1:W+1]);
        t[i]    <= (DW'(ph[i]) <<< (W+1)) + DW'(pl[i]);
      end
      det <= t[0] + t[1] + t[2];
      for (int s = 2; s <= 6; s++) begin
        kp[s] <= kp[s-1];
      end
      den <= det[DW-1] ? DW'(-det) : DW'(det);
      ok  <= dnz;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          num[r*3+c]  <= NW'(cabs[c][r]) << (2*FRAC_BITS);
          neg[r*3+c]  <= c6[c][r][CW-1] ^ det[DW-1];
          keep[r*3+c] <= kp[6][r*3+c] & dnz;
        end
      end
    end
  end

  always_comb begin
    dnz = (det != '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cabs[i][j] = c6[i][j][CW-1] ? (2*W)'(-c6[i][j]) : (2*W)'(c6[i][j]);
      end
    end
  end

endmodule

[sv/mia_lane.sv]
module mia_lane #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  adv,
  input  logic [2*ENTRY_WIDTH+2*FRAC_BITS-1:0]  num,
  input  logic [3*ENTRY_WIDTH+1:0]              den,
  input  logic                                  neg,
  input  logic                                  keep,
  output logic signed [ENTRY_WIDTH-1:0]         inv
);
  import mia_pkg::*;

  localparam int W  = ENTRY_WIDTH;
  localparam int NW = 2*W + 2*FRAC_BITS;
  localparam int DW = 3*W + 2;
  localparam int XW = (NW > DW + W ? NW : DW + W) + 1;

  logic [NW-1:0] rr [0:W];
  logic [DW-1:0] dd [0:W];
  logic [W-1:0]  qq [0:W];
  logic          sg [0:W];
  logic          kp [0:W];
  logic          ov [0:W];
  logic          big;
  logic          over_half;

  always_ff @(posedge clk) begin
    if (adv) begin
      rr[0] <= num;
      dd[0] <= den;
      qq[0] <= '0;
      sg[0] <= neg;
      kp[0] <= keep;
      ov[0] <= XW'(num) >= (XW'(den) << W);
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int K = W - s;
    logic [XW-1:0] sh;
    logic [XW-1:0] rx;
    logic          ge;
    assign sh = XW'(dd[s-1]) << K;
    assign rx = XW'(rr[s-1]);
    assign ge = rx >= sh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rr[s] <= ge ? NW'(rx - sh) : rr[s-1];
        qq[s] <= qq[s-1] | (ge ? (W'(1) << K) : '0);
        dd[s] <= dd[s-1];
        sg[s] <= sg[s-1];
        kp[s] <= kp[s-1];
        ov[s] <= ov[s-1];
      end
    end
  end

  assign big       = ov[W] || qq[W][W-1];
  assign over_half = ov[W] || (qq[W] > (W'(1) << (W-1)));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!kp[W]) begin
        inv <= '0;
      end else if (sg[W]) begin
        inv <= over_half ? {1'b1, {(W-1){1'b0}}} : -$signed(qq[W]);
      end else begin
        inv <= big ? {1'b0, {(W-1){1'b1}}} : $signed(qq[W]);
      end
    end
  end

endmodule

[sv/matrix_inverse_3x3_adjugate.sv]
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Input channel (in_valid/in_ready) takes one word: nine entries m00..m22.
// Output channel (out_valid/out_ready) gives ok and inv00..inv22.
// Config channel (cfg_valid/cfg_ready, cfg_data) sets the order 1..3; write
// only while the block is idle. cfg_ready is always high.
// Throughput: one word per cycle while the skid register is empty. The
// quotient is formed one bit per stage in nine parallel divider lanes,
// ENTRY_WIDTH stages deep; the front end takes seven stages for products,
// cofactors and determinant.
// Reset clears all valid flags and sets the order to 3; in-flight words are
// dropped.
// A skid register behind the output lets the last stage empty once when the
// receiver stalls; after that the whole pipeline holds and in_ready falls.
// in_ready depends only on registered state.
module matrix_inverse_3x3_adjugate #(
  parameter int ENTRY_WIDTH = mia_pkg::ENTRY_WIDTH_DEF,
  parameter int FRAC_BITS   = mia_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ENTRY_WIDTH-1:0] m00,
  input  logic signed [ENTRY_WIDTH-1:0] m01,
  input  logic signed [ENTRY_WIDTH-1:0] m02,
  input  logic signed [ENTRY_WIDTH-1:0] m10,
  input  logic signed [ENTRY_WIDTH-1:0] m11,
  input  logic signed [ENTRY_WIDTH-1:0] m12,
  input  logic signed [ENTRY_WIDTH-1:0] m20,
  input  logic signed [ENTRY_WIDTH-1:0] m21,
  input  logic signed [ENTRY_WIDTH-1:0] m22,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic signed [ENTRY_WIDTH-1:0] inv00,
  output logic signed [ENTRY_WIDTH-1:0] inv01,
  output logic signed [ENTRY_WIDTH-1:0] inv02,
  output logic signed [ENTRY_WIDTH-1:0] inv10,
  output logic signed [ENTRY_WIDTH-1:0] inv11,
  output logic signed [ENTRY_WIDTH-1:0] inv12,
  output logic signed [ENTRY_WIDTH-1:0] inv20,
  output logic signed [ENTRY_WIDTH-1:0] inv21,
  output logic signed [ENTRY_WIDTH-1:0] inv22
);
  import mia_pkg::*;

  localparam int W  = ENTRY_WIDTH;
  localparam int NW = 2*W + 2*FRAC_BITS;
  localparam int DW = 3*W + 2;
  localparam int LS = W + 2;
  localparam int T  = FRONT_STAGES + LS;

  logic [1:0]          order;
  logic [T-1:0]        vld;
  logic                adv;
  logic                push;
  logic                pop;
  logic                sk_full;
  logic signed [W-1:0] mv     [9];
  logic [NW-1:0]       num    [9];
  logic [DW-1:0]       den;
  logic [8:0]          neg;
  logic [8:0]          keep;
  logic                f_ok;
  logic                okp    [0:LS-1];
  logic signed [W-1:0] lv     [9];
  logic signed [W-1:0] ov_r   [9];
  logic signed [W-1:0] sk_v   [9];
  logic                sk_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RESET;
    end else if (cfg_valid) begin
      order <= cfg_data;
    end
  end

  assign mv[0] = m00;
  assign mv[1] = m01;
  assign mv[2] = m02;
  assign mv[3] = m10;
  assign mv[4] = m11;
  assign mv[5] = m12;
  assign mv[6] = m20;
  assign mv[7] = m21;
  assign mv[8] = m22;

  assign adv      = !sk_full;
  assign in_ready = adv;
  assign push     = adv && vld[T-1];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T-2:0], in_valid};
    end
  end

  mia_front #(.ENTRY_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .adv   (adv),
    .ord_n (clamp_order(order)),
    .m     (mv),
    .num   (num),
    .den   (den),
    .neg   (neg),
    .keep  (keep),
    .ok    (f_ok)
  );

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_lane
    mia_lane #(.ENTRY_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .num  (num[g]),
      .den  (den),
      .neg  (neg[g]),
      .keep (keep[g]),
      .inv  (lv[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okp[0] <= f_ok;
      for (int s = 1; s < LS; s++) begin
        okp[s] <= okp[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_full   <= 1'b0;
    end else if (sk_full) begin
      if (pop) begin
        ok      <= sk_ok;
        ov_r    <= sk_v;
        sk_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        ok        <= okp[LS-1];
        ov_r      <= lv;
        out_valid <= 1'b1;
      end else begin
        sk_ok   <= okp[LS-1];
        sk_v    <= lv;
        sk_full <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign inv00 = ov_r[0];
  assign inv01 = ov_r[1];
  assign inv02 = ov_r[2];
  assign inv10 = ov_r[3];
  assign inv11 = ov_r[4];
  assign inv12 = ov_r[5];
  assign inv20 = ov_r[6];
  assign inv21 = ov_r[7];
  assign inv22 = ov_r[8];

endmodule

[sv/mia_check.sv]
module mia_check #(
  parameter int ENTRY_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          ok,
  input logic signed [ENTRY_WIDTH-1:0] inv00,
  input logic signed [ENTRY_WIDTH-1:0] inv11,
  input logic signed [ENTRY_WIDTH-1:0] inv22
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> inv00 == '0 && inv11 == '0 && inv22 == '0)
    else $error("singular result not cleared");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("input stalled with empty output");

endmodule

bind matrix_inverse_3x3_adjugate mia_check #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_mia_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ok        (ok),
  .inv00     (inv00),
  .inv11     (inv11),
  .inv22     (inv22)
);

[sim/tb_matrix_inverse_3x3_adjugate.sv]
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3_adjugate;
  import mia_pkg::*;

  typedef logic signed [31:0]  ent_t;
  typedef logic signed [191:0] wide_t;
  typedef struct {
    logic ok;
    ent_t inv[9];
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  ent_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
  ent_t m20 = '0, m21 = '0, m22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  ent_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;

  inverse_t expected_inverses[$];
  logic [1:0] order_now = ORDER_RESET;
  int   n_errors = 0;
  bit   no_gaps = 1'b0;

  matrix_inverse_3x3_adjugate u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
    .inv00(inv00), .inv01(inv01), .inv02(inv02), .inv10(inv10), .inv11(inv11),
    .inv12(inv12), .inv20(inv20), .inv21(inv21), .inv22(inv22)
  );

  always #5 clk = ~clk;

  function automatic wide_t minor2(wide_t m[3][3], int r, int c);
    int r0, r1, c0, c1;
    r0 = (r == 0) ? 1 : 0;
    r1 = (r == 2) ? 1 : 2;
    c0 = (c == 0) ? 1 : 0;
    c1 = (c == 2) ? 1 : 2;
    return m[r0][c0] * m[r1][c1] - m[r0][c1] * m[r1][c0];
  endfunction

  function automatic inverse_t predict_inverse(ent_t a[9], logic [1:0] ord);
    inverse_t res;
    wide_t m[3][3];
    wide_t det, cof, quo;
    int n;
    n = (ord == 2'd0) ? 1 : int'(ord);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (i < n && j < n) ? wide_t'(a[i*3+j]) : '0;
    if (n == 1)
      det = m[0][0];
    else if (n == 2)
      det = m[0][0] * m[1][1] - m[0][1] * m[1][0];
    else
      det = m[0][0] * minor2(m, 0, 0) - m[0][1] * minor2(m, 0, 1)
          + m[0][2] * minor2(m, 0, 2);
    res.ok = (det != 0);
    for (int k = 0; k < 9; k++) res.inv[k] = '0;
    if (!res.ok) return res;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        // adjugate entry (i,j) is the cofactor at (j,i)
        if (n == 1)
          cof = 1;
        else if (n == 2)
          cof = m[1-j][1-i];
        else
          cof = minor2(m, j, i);
        if ((i + j) % 2 == 1) cof = -cof;
        quo = (cof <<< 32) / det;
        if (quo > wide_t'(32'sh7fffffff))
          res.inv[i*3+j] = 32'sh7fffffff;
        else if (quo < -wide_t'(64'sh80000000))
          res.inv[i*3+j] = 32'sh80000000;
        else
          res.inv[i*3+j] = quo[31:0];
      end
    return res;
  endfunction

  // result side: random stalls, checks each accepted word
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    inverse_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.ok = ok;
      got.inv = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
      if (expected_inverses.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word ok=%0b", ok);
      end else begin
        want = expected_inverses.pop_front();
        if (got.ok !== want.ok) begin
          n_errors++;
          if (n_errors <= 10) $display("ok: expected %0b got %0b", want.ok, got.ok);
        end
        for (int k = 0; k < 9; k++)
          if (got.inv[k] !== want.inv[k]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("inv%0d%0d: expected %0d got %0d", k / 3, k % 3,
                       want.inv[k], got.inv[k]);
          end
      end
    end
  end

  task automatic send_matrix(ent_t a[9]);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_inverses.push_back(predict_inverse(a, order_now));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_inverses.size() != 0) @(posedge clk);
  endtask

  task automatic set_order(logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order_now = v;
  endtask

  function automatic ent_t rand_entry();
    case ($urandom_range(0, 5))
      0:       return ent_t'($urandom);
      1:       return ent_t'(1) <<< $urandom_range(0, 31);
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return ent_t'($urandom_range(0, 1048575)) - 32'sd524288;
    endcase
  endfunction

  function automatic void rand_matrix(output ent_t a[9]);
    for (int k = 0; k < 9; k++) a[k] = rand_entry();
    // singular by repeated or scaled rows
    if ($urandom_range(0, 7) == 0) begin
      for (int c = 0; c < 3; c++) a[3+c] = a[c];
    end else if ($urandom_range(0, 9) == 0) begin
      for (int c = 0; c < 3; c++) a[6+c] = a[c] <<< 1;
    end
  endfunction

  task automatic test_directed;
    ent_t a[9];
    a = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(a);
    a = '{default: 0};
    send_matrix(a);
    a = '{default: 32'sh7fffffff};
    send_matrix(a);
    a = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
    send_matrix(a);
    a = '{32'sh7fffffff, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7fffffff};
    send_matrix(a);
    a = '{1, 0, 0, 0, 1, 0, 0, 0, -1};
    send_matrix(a);
    a = '{32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh30000, 32'sh10000,
          0, 32'sh10000, 32'sh40000};
    send_matrix(a);
    a = '{-1, 32'sh80000000, 32'sh7fffffff, 5, -3, 32'sh12345678,
          32'shfedcba98, 7, 32'sh80000000};
    send_matrix(a);
    drain();
  endtask

  task automatic test_orders;
    ent_t a[9];
    logic [1:0] ords[4] = '{2'd1, 2'd2, 2'd0, 2'd3};
    foreach (ords[i]) begin
      set_order(ords[i]);
      a = '{32'sh10000, 32'sh7fffffff, -5, 32'sh80000000, 32'sh20000, 9, 3, 4, 0};
      send_matrix(a);
      a = '{0, 1, 2, 3, 4, 5, 6, 7, 8};
      send_matrix(a);
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(a);
      a = '{32'sh80000000, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1};
      send_matrix(a);
    end
    drain();
  endtask

  task automatic test_random;
    ent_t a[9];
    for (int i = 0; i < 450; i++) begin
      if (i % 75 == 0) set_order(2'($urandom_range(0, 3)));
      no_gaps = (i % 75) >= 50;
      if (i == 200) drain();
      rand_matrix(a);
      send_matrix(a);
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_orders();
    test_random();
    repeat (60) @(posedge clk);
    if (n_errors == 0 && expected_inverses.size() == 0)
      $display("tb_matrix_inverse_3x3_adjugate: done, clean");
    else
      $display("tb_matrix_inverse_3x3_adjugate: done, errors");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_matrix_inverse_3x3_adjugate: done, errors");
    $finish;
  end

endmodule

[matrix_inverse_3x3_adjugate.f]
sv/mia_pkg.sv
sv/mia_front.sv
sv/mia_lane.sv
sv/matrix_inverse_3x3_adjugate.sv
sv/mia_check.sv
sim/tb_matrix_inverse_3x3_adjugate.sv
